FILE: hdl/pfcs_pkg.sv
// ----------------------------------------------------------------------------
// Particle frame check package
// Shared constants, codes and types for the frame checker and statistics
// store.
// ----------------------------------------------------------------------------
package pfcs_pkg;

   // default frame length and fraction bits of the average
   localparam int FRAME_BYTES_DEF  = 29;
   localparam int AVG_FRAC_DEF     = 4;

   // field widths
   localparam int NUM_CH     = 3;
   localparam int SUM_W      = 24;
   localparam int READING_W  = 16;
   localparam int ID_W       = 16;
   localparam int COUNT_W    = 8;
   localparam int AVG_W      = 20;
   localparam int CH_W       = 2;

   // byte offsets inside a frame
   localparam int SENSOR_ID_POS = 3;
   localparam int CHAN_OFFSET [NUM_CH] = '{10, 12, 14};

   // highest sample count
   localparam logic [COUNT_W-1:0] COUNT_FULL = '1;

   // command codes
   localparam logic CMD_FRAME_BYTE = 1'b0;
   localparam logic CMD_SUMMARY    = 1'b1;

   typedef enum logic {
      KIND_VERDICT = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_BAD_SUM  = 2'd1,
      STATUS_FULL     = 2'd2
   } frame_status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_EMIT   = 2'd2
   } seq_state_type;

   typedef logic [NUM_CH-1:0][READING_W-1:0] reading_array_type;

   // end-of-frame report from the frame parser
   typedef struct packed {
      logic done;
      logic sum_ok;
   } frame_evt_type;

endpackage

FILE: hdl/pfcs_if.sv
// ----------------------------------------------------------------------------
// Particle frame check channels
// Valid/ready channels for frame words in and result words out.
// ----------------------------------------------------------------------------
interface pfcs_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] byte_value;
   logic       first_byte;

   modport source (output valid, command, byte_value, first_byte, input ready);
   modport sink   (input valid, command, byte_value, first_byte, output ready);
endinterface

interface pfcs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic [1:0]                          frame_status;
   logic [pfcs_pkg::CH_W-1:0]           channel;
   logic [pfcs_pkg::AVG_W-1:0]          average_fixed;
   logic [pfcs_pkg::READING_W-1:0]      maximum;
   logic [pfcs_pkg::ID_W-1:0]           sensor_id;
   logic [pfcs_pkg::COUNT_W-1:0]        samples;
   logic                                last;

   modport source (output valid, kind, frame_status, channel, average_fixed, maximum,
                   sensor_id, samples, last, input ready);
   modport sink   (input valid, kind, frame_status, channel, average_fixed, maximum,
                   sensor_id, samples, last, output ready);
endinterface

FILE: hdl/particle_frame_check_and_statistics.sv
// ----------------------------------------------------------------------------
// Particle frame check and statistics
// Checks sensor frames by additive checksum, keeps per-channel sums, maxima,
// sensor number and sample count, and emits a three-line summary on demand.
// ----------------------------------------------------------------------------
//  channel   dir  words
//  req_chan  in   command, byte_value, first_byte
//  rsp_chan  out  kind, frame_status, channel, average_fixed, maximum,
//                 sensor_id, samples, last
//
//  The checksum word loads its verdict into the output register, and a new
//  word is taken while that register drains. A summary runs the bit-serial
//  divider once per channel; no word is taken meanwhile. A stalled rsp_chan
//  holds the output register and the summary.
//  Reset is synchronous and clears the store; no clearing pass is needed.
// ----------------------------------------------------------------------------
module particle_frame_check_and_statistics #(
   parameter int FRAME_BYTES           = pfcs_pkg::FRAME_BYTES_DEF,
   parameter int AVERAGE_FRACTION_BITS = pfcs_pkg::AVG_FRAC_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pfcs_req_if.sink    req_chan,
   pfcs_rsp_if.source  rsp_chan
);

   localparam int DIV_W = pfcs_pkg::SUM_W + AVERAGE_FRACTION_BITS;
   localparam int CH_W  = pfcs_pkg::CH_W;
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(pfcs_pkg::NUM_CH - 1);

   // sequencer
   pfcs_pkg::seq_state_type state_ff, state_in;
   logic [CH_W-1:0]         ch_ff, ch_in;

   // statistics store
   logic [pfcs_pkg::SUM_W-1:0]     sum_ff [pfcs_pkg::NUM_CH];
   logic [pfcs_pkg::SUM_W-1:0]     sum_in [pfcs_pkg::NUM_CH];
   logic [pfcs_pkg::READING_W-1:0] max_ff [pfcs_pkg::NUM_CH];
   logic [pfcs_pkg::READING_W-1:0] max_in [pfcs_pkg::NUM_CH];
   logic [pfcs_pkg::ID_W-1:0]      sid_ff, sid_in;
   logic [pfcs_pkg::COUNT_W-1:0]   total_ff, total_in;

   // output register
   logic                              out_valid_ff, out_valid_in;
   pfcs_pkg::kind_type                out_kind_ff, out_kind_in;
   pfcs_pkg::frame_status_type        out_status_ff, out_status_in;
   logic [CH_W-1:0]                   out_ch_ff, out_ch_in;
   logic [pfcs_pkg::AVG_W-1:0]        out_avg_ff, out_avg_in;
   logic [pfcs_pkg::READING_W-1:0]    out_max_ff, out_max_in;
   logic [pfcs_pkg::ID_W-1:0]         out_sid_ff, out_sid_in;
   logic [pfcs_pkg::COUNT_W-1:0]      out_smp_ff, out_smp_in;
   logic                              out_last_ff, out_last_in;

   // control
   logic                              req_acc;
   logic                              out_free;
   logic                              div_start;
   logic [CH_W-1:0]                   div_ch;
   logic                              emit;
   logic                              clear_store;
   logic                              div_done;
   logic [DIV_W-1:0]                  div_dividend;
   logic [DIV_W-1:0]                  quotient;
   logic [pfcs_pkg::AVG_W-1:0]        avg;
   pfcs_pkg::frame_evt_type           frame_evt;
   logic [pfcs_pkg::ID_W-1:0]         cap_id;
   pfcs_pkg::reading_array_type       cap_read;
   pfcs_pkg::frame_status_type        verdict;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign req_acc  = req_chan.valid && req_chan.ready;

   pfcs_frame #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_acc && (req_chan.command == pfcs_pkg::CMD_FRAME_BYTE)),
      .byte_value (req_chan.byte_value),
      .first_byte (req_chan.first_byte),
      .frame_evt  (frame_evt),
      .sensor_id  (cap_id),
      .readings   (cap_read)
   );

   // shift the selected sum up by the fraction bits
   assign div_dividend = DIV_W'(sum_ff[div_ch]) << AVERAGE_FRACTION_BITS;

   pfcs_div #(
      .DIVIDEND_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // saturate the quotient, zero when nothing was counted
   always_comb begin
      if (total_ff == '0) begin
         avg = '0;
      end else if (quotient[DIV_W-1:pfcs_pkg::AVG_W] != '0) begin
         avg = '1;
      end else begin
         avg = quotient[pfcs_pkg::AVG_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfcs_pkg::ST_IDLE: begin
            if (req_acc && (req_chan.command == pfcs_pkg::CMD_SUMMARY)) begin
               state_in = pfcs_pkg::ST_DIVIDE;
            end
         end
         pfcs_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = pfcs_pkg::ST_EMIT;
            end
         end
         pfcs_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = (ch_ff == LAST_CH) ? pfcs_pkg::ST_IDLE : pfcs_pkg::ST_DIVIDE;
            end
         end
         default: begin
            state_in = pfcs_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready = 1'b0;
      div_start      = 1'b0;
      div_ch         = ch_ff;
      emit           = 1'b0;
      clear_store    = 1'b0;
      unique case (state_ff)
         pfcs_pkg::ST_IDLE: begin
            req_chan.ready = out_free;
            if (req_acc && (req_chan.command == pfcs_pkg::CMD_SUMMARY)) begin
               div_start = 1'b1;
               div_ch    = '0;
            end
         end
         pfcs_pkg::ST_DIVIDE: begin
         end
         pfcs_pkg::ST_EMIT: begin
            if (out_free) begin
               emit = 1'b1;
               if (ch_ff == LAST_CH) begin
                  clear_store = 1'b1;
               end else begin
                  div_start = 1'b1;
                  div_ch    = ch_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign ch_in = div_start ? div_ch : ch_ff;

   // frame verdict
   always_comb begin
      if (!frame_evt.sum_ok) begin
         verdict = pfcs_pkg::STATUS_BAD_SUM;
      end else if (total_ff == pfcs_pkg::COUNT_FULL) begin
         verdict = pfcs_pkg::STATUS_FULL;
      end else begin
         verdict = pfcs_pkg::STATUS_ACCEPTED;
      end
   end

   // update or clear the store
   always_comb begin
      sid_in   = sid_ff;
      total_in = total_ff;
      for (int i = 0; i < pfcs_pkg::NUM_CH; i++) begin
         sum_in[i] = sum_ff[i];
         max_in[i] = max_ff[i];
      end
      if (clear_store) begin
         sid_in   = '0;
         total_in = '0;
         for (int i = 0; i < pfcs_pkg::NUM_CH; i++) begin
            sum_in[i] = '0;
            max_in[i] = '0;
         end
      end else if (frame_evt.done && (verdict == pfcs_pkg::STATUS_ACCEPTED)) begin
         sid_in   = cap_id;
         total_in = total_ff + 1'b1;
         for (int i = 0; i < pfcs_pkg::NUM_CH; i++) begin
            sum_in[i] = sum_ff[i] + pfcs_pkg::SUM_W'(cap_read[i]);
            if (cap_read[i] > max_ff[i]) begin
               max_in[i] = cap_read[i];
            end
         end
      end
   end

   // load the output register, drop it once taken
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_kind_in   = out_kind_ff;
      out_status_in = out_status_ff;
      out_ch_in     = out_ch_ff;
      out_avg_in    = out_avg_ff;
      out_max_in    = out_max_ff;
      out_sid_in    = out_sid_ff;
      out_smp_in    = out_smp_ff;
      out_last_in   = out_last_ff;
      if (frame_evt.done) begin
         out_valid_in  = 1'b1;
         out_kind_in   = pfcs_pkg::KIND_VERDICT;
         out_status_in = verdict;
         out_ch_in     = '0;
         out_avg_in    = '0;
         out_max_in    = '0;
         out_sid_in    = '0;
         out_smp_in    = '0;
         out_last_in   = 1'b1;
      end else if (emit) begin
         out_valid_in  = 1'b1;
         out_kind_in   = pfcs_pkg::KIND_SUMMARY;
         out_status_in = pfcs_pkg::STATUS_ACCEPTED;
         out_ch_in     = ch_ff;
         out_avg_in    = avg;
         out_max_in    = max_ff[ch_ff];
         out_sid_in    = sid_ff;
         out_smp_in    = total_ff;
         out_last_in   = (ch_ff == LAST_CH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfcs_pkg::ST_IDLE;
         ch_ff        <= '0;
         out_valid_ff <= 1'b0;
         sid_ff       <= '0;
         total_ff     <= '0;
         for (int i = 0; i < pfcs_pkg::NUM_CH; i++) begin
            sum_ff[i] <= '0;
            max_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         out_valid_ff <= out_valid_in;
         sid_ff       <= sid_in;
         total_ff     <= total_in;
         for (int i = 0; i < pfcs_pkg::NUM_CH; i++) begin
            sum_ff[i] <= sum_in[i];
            max_ff[i] <= max_in[i];
         end
      end
      out_kind_ff   <= out_kind_in;
      out_status_ff <= out_status_in;
      out_ch_ff     <= out_ch_in;
      out_avg_ff    <= out_avg_in;
      out_max_ff    <= out_max_in;
      out_sid_ff    <= out_sid_in;
      out_smp_ff    <= out_smp_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_kind_ff;
   assign rsp_chan.frame_status  = out_status_ff;
   assign rsp_chan.channel       = out_ch_ff;
   assign rsp_chan.average_fixed = out_avg_ff;
   assign rsp_chan.maximum       = out_max_ff;
   assign rsp_chan.sensor_id     = out_sid_ff;
   assign rsp_chan.samples       = out_smp_ff;
   assign rsp_chan.last          = out_last_ff;

endmodule

FILE: hdl/pfcs_frame.sv
// ----------------------------------------------------------------------------
// Particle frame parser
// Tracks byte position, runs the additive checksum and captures the sensor
// number and the three big-endian readings of the current frame.
// ----------------------------------------------------------------------------
module pfcs_frame #(
   parameter int FRAME_BYTES = pfcs_pkg::FRAME_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          byte_valid,
   input  logic [7:0]                    byte_value,
   input  logic                          first_byte,
   output pfcs_pkg::frame_evt_type       frame_evt,
   output logic [pfcs_pkg::ID_W-1:0]     sensor_id,
   output pfcs_pkg::reading_array_type   readings
);

   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

   logic [POS_W-1:0]              pos_ff, pos_in;
   logic                          open_ff, open_in;
   logic [7:0]                    csum_ff, csum_in;
   logic [7:0]                    high_ff, high_in;
   logic [pfcs_pkg::ID_W-1:0]     id_ff, id_in;
   pfcs_pkg::reading_array_type   read_ff, read_in;

   logic                          active;
   logic                          is_end;
   logic [POS_W-1:0]              cur_pos;
   logic [7:0]                    cur_csum;
   logic [7:0]                    cur_high;

   // restart on a first mark, otherwise continue the open frame
   always_comb begin
      active   = byte_valid && (first_byte || open_ff);
      cur_pos  = first_byte ? '0 : pos_ff;
      cur_csum = first_byte ? '0 : csum_ff;
      cur_high = first_byte ? '0 : high_ff;
      is_end   = active && !first_byte && (pos_ff == LAST_POS);
   end

   // advance position, checksum and captured fields
   always_comb begin
      pos_in   = pos_ff;
      open_in  = open_ff;
      csum_in  = csum_ff;
      high_in  = high_ff;
      id_in    = first_byte && byte_valid ? '0 : id_ff;
      read_in  = first_byte && byte_valid ? '0 : read_ff;
      if (is_end) begin
         pos_in  = '0;
         open_in = 1'b0;
      end else if (active) begin
         open_in = 1'b1;
         pos_in  = cur_pos + 1'b1;
         csum_in = cur_csum + byte_value;
         if (!cur_pos[0]) begin
            high_in = byte_value;
         end
         if (cur_pos == POS_W'(pfcs_pkg::SENSOR_ID_POS)) begin
            id_in = {cur_high, byte_value};
         end
         for (int i = 0; i < pfcs_pkg::NUM_CH; i++) begin
            if (cur_pos == POS_W'(pfcs_pkg::CHAN_OFFSET[i] + 1)) begin
               read_in[i] = {cur_high, byte_value};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         open_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         open_ff <= open_in;
      end
      csum_ff <= csum_in;
      high_ff <= high_in;
      id_ff   <= id_in;
      read_ff <= read_in;
   end

   // report the checksum byte
   assign frame_evt.done   = is_end;
   assign frame_evt.sum_ok = (csum_ff == byte_value);
   assign sensor_id        = id_ff;
   assign readings         = read_ff;

endmodule

FILE: hdl/pfcs_div.sv
// ----------------------------------------------------------------------------
// Particle average divider
// Restoring divider by an 8-bit count, one quotient bit per cycle through a
// shift register.
// ----------------------------------------------------------------------------
module pfcs_div #(
   parameter int DIVIDEND_W = pfcs_pkg::SUM_W + pfcs_pkg::AVG_FRAC_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [DIVIDEND_W-1:0]            dividend,
   input  logic [pfcs_pkg::COUNT_W-1:0]     divisor,
   output logic                             done,
   output logic [DIVIDEND_W-1:0]            quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);
   localparam int REM_W = pfcs_pkg::COUNT_W;

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] shift_ff, shift_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [REM_W-1:0]      dvs_ff, dvs_in;
   logic                  done_ff, done_in;

   logic [REM_W:0]        trial;
   logic [REM_W:0]        diff;
   logic                  ge;

   // one trial subtract per cycle
   always_comb begin
      trial = {rem_ff, shift_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = (trial >= {1'b0, dvs_ff});
   end

   // load on start, shift while busy
   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      done_in  = 1'b0;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(DIVIDEND_W);
         shift_in = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         shift_in = {shift_ff[DIVIDEND_W-2:0], ge};
         rem_in   = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Particle frame check testbench
// Drives frame words and summary commands into the frame checker under random
// idling and back-pressure. A scoreboard predicts every verdict and summary
// line and compares each received word field by field, in order.
// ----------------------------------------------------------------------------
module tb;
   import pfcs_pkg::*;

   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 12;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RANDOM_WORDS   = 105;
   localparam int LONG_HOLD      = 400;
   localparam int MAX_REPORTS    = 10;
   // a summary runs the divider three times
   localparam int DRAIN_CYCLES   = 150;

   typedef struct packed {
      kind_type                kind;
      frame_status_type        status;
      logic [CH_W-1:0]         channel;
      logic [AVG_W-1:0]        average;
      logic [READING_W-1:0]    maximum;
      logic [ID_W-1:0]         sensor_id;
      logic [COUNT_W-1:0]      samples;
      logic                    last;
   } pm_result_type;

   typedef logic [7:0] frame_image_type [FRAME_BYTES_DEF];

   // -------------------------------------------------------------------------
   // Frame checker and statistics predictor with its queue of pending results
   // -------------------------------------------------------------------------
   class pm_stats_scoreboard;
      logic [4:0]           byte_pos;
      logic                 frame_open;
      logic [7:0]           checksum;
      logic [7:0]           high_hold;
      logic [ID_W-1:0]      frame_id;
      logic [READING_W-1:0] frame_reading [NUM_CH];
      logic [SUM_W-1:0]     sums [NUM_CH];
      logic [READING_W-1:0] maxima [NUM_CH];
      logic [ID_W-1:0]      kept_id;
      logic [COUNT_W-1:0]   count;
      pm_result_type        pending_q [$];
      int                   expected_total;
      int                   mismatches;
      int                   verdicts_seen;
      int                   summaries_seen;

      function new();
         int ch;
         byte_pos   = '0;
         frame_open = 1'b0;
         checksum   = '0;
         high_hold  = '0;
         frame_id   = '0;
         for (ch = 0; ch < NUM_CH; ch++) frame_reading[ch] = '0;
         clear_store();
         expected_total = 0;
         mismatches     = 0;
         verdicts_seen  = 0;
         summaries_seen = 0;
      endfunction

      function void clear_store();
         int ch;
         for (ch = 0; ch < NUM_CH; ch++) begin
            sums[ch]   = '0;
            maxima[ch] = '0;
         end
         kept_id = '0;
         count   = '0;
      endfunction

      function void push_verdict(frame_status_type st);
         pm_result_type line;
         line        = '0;
         line.kind   = KIND_VERDICT;
         line.status = st;
         line.last   = 1'b1;
         pending_q.push_back(line);
         expected_total++;
      endfunction

      // Note an accepted word; return 0 when the block simply drops it.
      function bit note_word(logic cmd, logic [7:0] value, logic first);
         int                                ch;
         logic [READING_W-1:0]              word;
         logic [SUM_W+AVG_FRAC_DEF-1:0]     scaled;
         logic [SUM_W+AVG_FRAC_DEF-1:0]     quotient;
         pm_result_type                     line;
         // summary: one line per channel, then clear the store
         if (cmd == CMD_SUMMARY) begin
            for (ch = 0; ch < NUM_CH; ch++) begin
               quotient = '0;
               if (count != 0) begin
                  scaled   = {sums[ch], {AVG_FRAC_DEF{1'b0}}};
                  quotient = scaled / count;
               end
               line           = '0;
               line.kind      = KIND_SUMMARY;
               line.status    = STATUS_ACCEPTED;
               line.channel   = CH_W'(ch);
               line.average   = (quotient > {AVG_W{1'b1}}) ? '1 : quotient[AVG_W-1:0];
               line.maximum   = maxima[ch];
               line.sensor_id = kept_id;
               line.samples   = count;
               line.last      = (ch == NUM_CH - 1);
               pending_q.push_back(line);
               expected_total++;
            end
            clear_store();
            return 1'b1;
         end
         // first mark restarts the frame, unmarked words outside a frame drop
         if (first) begin
            frame_open = 1'b1;
            byte_pos   = '0;
            checksum   = '0;
            high_hold  = '0;
            frame_id   = '0;
            for (ch = 0; ch < NUM_CH; ch++) frame_reading[ch] = '0;
         end else if (!frame_open) begin
            return 1'b0;
         end
         // body word: sum it and capture big-endian fields
         if (byte_pos < FRAME_BYTES_DEF - 1) begin
            checksum = checksum + value;
            if (byte_pos[0] == 1'b0) begin
               high_hold = value;
            end else begin
               word = {high_hold, value};
               if (byte_pos == SENSOR_ID_POS) frame_id = word;
               for (ch = 0; ch < NUM_CH; ch++)
                  if (byte_pos == CHAN_OFFSET[ch] + 1) frame_reading[ch] = word;
            end
            byte_pos++;
            return 1'b1;
         end
         // checksum word closes the frame
         frame_open = 1'b0;
         byte_pos   = '0;
         if (checksum != value) begin
            push_verdict(STATUS_BAD_SUM);
         end else if (count == COUNT_FULL) begin
            push_verdict(STATUS_FULL);
         end else begin
            kept_id = frame_id;
            for (ch = 0; ch < NUM_CH; ch++) begin
               sums[ch] = sums[ch] + frame_reading[ch];
               if (frame_reading[ch] > maxima[ch]) maxima[ch] = frame_reading[ch];
            end
            count++;
            push_verdict(STATUS_ACCEPTED);
         end
         return 1'b1;
      endfunction

      function string to_text(pm_result_type r);
         return $sformatf("kind %0d status %0d ch %0d avg %0d max %0d id %0d smp %0d last %0d",
                          r.kind, r.status, r.channel, r.average, r.maximum, r.sensor_id,
                          r.samples, r.last);
      endfunction

      // Compare a received word with the oldest pending result.
      function void check_result(pm_result_type got);
         pm_result_type want;
         if (got.kind == KIND_SUMMARY) summaries_seen++;
         else verdicts_seen++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: result with nothing pending: %s", to_text(got));
            return;
         end
         want = pending_q.pop_front();
         if (got.kind !== want.kind || got.status !== want.status ||
             got.channel !== want.channel || got.average !== want.average ||
             got.maximum !== want.maximum || got.sensor_id !== want.sensor_id ||
             got.samples !== want.samples || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("ERROR: result mismatch");
               $display("   expected %s", to_text(want));
               $display("   actual   %s", to_text(got));
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   pfcs_req_if req_chan ();
   pfcs_rsp_if rsp_chan ();

   particle_frame_check_and_statistics u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pm_stats_scoreboard scoreboard;
   bit  idle_on;
   int  long_hold_req;
   int  words_used;
   int  cycle_count;

   // clock
   always #(CLOCK_HALF) clock = ~clock;

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Result side: check accepted words, stall in bursts or one long hold
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : sink_side
      int            hold_left;
      pm_result_type got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind      = kind_type'(rsp_chan.kind);
            got.status    = frame_status_type'(rsp_chan.frame_status);
            got.channel   = rsp_chan.channel;
            got.average   = rsp_chan.average_fixed;
            got.maximum   = rsp_chan.maximum;
            got.sensor_id = rsp_chan.sensor_id;
            got.samples   = rsp_chan.samples;
            got.last      = rsp_chan.last;
            scoreboard.check_result(got);
         end
         if (long_hold_req != 0) begin
            hold_left     = long_hold_req;
            long_hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 13) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Input side
   // -------------------------------------------------------------------------
   task automatic pause_source(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Offer one word, hold until taken, then maybe idle.
   task automatic push_word(input logic cmd, input logic [7:0] value, input logic first);
      req_chan.valid      <= 1'b1;
      req_chan.command    <= cmd;
      req_chan.byte_value <= value;
      req_chan.first_byte <= first;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      void'(scoreboard.note_word(cmd, value, first));
      words_used++;
      if (idle_on && $urandom_range(0, 7) == 0) pause_source($urandom_range(1, 13));
   endtask

   // Hold off the input until every pending result has come back.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (scoreboard.pending_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [READING_W-1:0] pick_reading();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         default: return READING_W'($urandom);
      endcase
   endfunction

   // Fill a frame with random bytes, place the fields and the checksum.
   task automatic build_frame(output frame_image_type img, input logic [ID_W-1:0] id,
                              input logic [READING_W-1:0] r0, r1, r2, input bit corrupt);
      logic [READING_W-1:0] rd [NUM_CH];
      logic [7:0]           sum;
      int                   i;
      rd  = '{r0, r1, r2};
      sum = '0;
      for (i = 0; i < FRAME_BYTES_DEF - 1; i++) img[i] = 8'($urandom);
      img[SENSOR_ID_POS-1] = id[15:8];
      img[SENSOR_ID_POS]   = id[7:0];
      for (i = 0; i < NUM_CH; i++) begin
         img[CHAN_OFFSET[i]]   = rd[i][15:8];
         img[CHAN_OFFSET[i]+1] = rd[i][7:0];
      end
      for (i = 0; i < FRAME_BYTES_DEF - 1; i++) sum = sum + img[i];
      img[FRAME_BYTES_DEF-1] = corrupt ? sum + 8'($urandom_range(1, 255)) : sum;
   endtask

   task automatic send_words(input frame_image_type img, input int from, input int upto);
      int i;
      for (i = from; i < upto; i++) push_word(CMD_FRAME_BYTE, img[i], i == 0);
   endtask

   task automatic send_random_frame(input bit corrupt, input int length);
      frame_image_type img;
      build_frame(img, ID_W'($urandom), pick_reading(), pick_reading(), pick_reading(),
                  corrupt);
      send_words(img, 0, length);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : main_flow
      frame_image_type img;
      int              pick;
      scoreboard          = new();
      clock               = 1'b0;
      reset               = 1'b1;
      idle_on             = 1'b1;
      long_hold_req       = 0;
      words_used          = 0;
      cycle_count         = 0;
      req_chan.valid      = 1'b0;
      req_chan.command    = CMD_FRAME_BYTE;
      req_chan.byte_value = '0;
      req_chan.first_byte = 1'b0;
      rsp_chan.ready      = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // summary on an empty store reads all zero
      push_word(CMD_SUMMARY, 8'h00, 1'b0);
      // unmarked word with no frame open
      push_word(CMD_FRAME_BYTE, 8'hFF, 1'b0);
      // largest readings and sensor number
      build_frame(img, '1, '1, '1, '1, 1'b0);
      send_words(img, 0, FRAME_BYTES_DEF);
      // words after the checksum word are dropped
      push_word(CMD_FRAME_BYTE, 8'h00, 1'b0);
      push_word(CMD_FRAME_BYTE, 8'hFF, 1'b0);
      // partial frame, then a restart that discards it
      build_frame(img, 16'h1234, 16'h0102, 16'h0304, 16'h0506, 1'b0);
      send_words(img, 0, 12);
      // summary in the middle of a frame leaves the frame running
      build_frame(img, '0, 16'h0001, 16'h8000, 16'h7FFF, 1'b0);
      send_words(img, 0, 14);
      push_word(CMD_SUMMARY, 8'hFF, 1'b1);
      send_words(img, 14, FRAME_BYTES_DEF);
      // checksum mismatch
      send_random_frame(1'b1, FRAME_BYTES_DEF);
      push_word(CMD_SUMMARY, 8'h5A, 1'b0);
      wait_drained();

      // hold the result side while frames keep coming
      long_hold_req = LONG_HOLD;
      repeat (2) send_random_frame(1'b0, FRAME_BYTES_DEF);
      push_word(CMD_SUMMARY, 8'hA5, 1'b1);
      wait_drained();

      // random mix, mostly well-formed frames; last third without idling
      words_used = 0;
      while (words_used < RANDOM_WORDS) begin
         if (words_used >= RANDOM_WORDS * 2 / 3) idle_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 68) begin
            send_random_frame(1'b0, FRAME_BYTES_DEF);
         end else if (pick < 78) begin
            send_random_frame(1'b1, FRAME_BYTES_DEF);
         end else if (pick < 86) begin
            send_random_frame(1'b0, $urandom_range(1, FRAME_BYTES_DEF - 1));
         end else if (pick < 93) begin
            repeat ($urandom_range(1, 4)) push_word(CMD_FRAME_BYTE, 8'($urandom), 1'b0);
         end else begin
            push_word(CMD_SUMMARY, 8'($urandom), 1'($urandom_range(0, 1)));
         end
      end
      push_word(CMD_SUMMARY, 8'($urandom), 1'b0);

      // drain, then watch for stray results
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d verdicts and %0d summary lines, %0d mismatches.",
               scoreboard.verdicts_seen, scoreboard.summaries_seen, scoreboard.mismatches);
      $display("Covered empty stores, restarts, short frames, bad sums and long back-pressure.");
      if (scoreboard.mismatches == 0 && scoreboard.pending_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
